@@ design/plik_pkg.sv @@
// ----------------------------------------------------------------------------
// plik_pkg: shared types and constants for the two-link planar IK block
// Transaction payload structs, CORDIC table and fixed-point helpers.
// ----------------------------------------------------------------------------
package plik_pkg;

  // Width of the CORDIC rotation datapath and of its angle accumulator.
  localparam int CordicW    = 34;
  localparam int CordicIter = 30;
  // Radicand and root widths of the square-root pipeline.
  localparam int RadW  = 54;
  localparam int RootW = 27;

  localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic [31:0]               ReachQ24  = 32'd67108864;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic        [13:0] elbow_angle;
    logic signed [15:0] wrist_angle;
  } out_t;

  // Sideband that travels beside the square-root pipeline.
  typedef struct packed {
    logic signed [CordicW-1:0] theta;
    logic                      far;
    logic                      origin;
    logic [RootW-1:0]          r2;
  } side_t;

  // atan(2^-i) in Q30 radians.
  function automatic logic signed [CordicW-1:0] atan_lut(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h3243F6A8;  1:  t = 32'h1DAC6705;  2:  t = 32'h0FADBAFC;
      3:  t = 32'h07F56EA6;  4:  t = 32'h03FEAB76;  5:  t = 32'h01FFD55B;
      6:  t = 32'h00FFFAAA;  7:  t = 32'h007FFF55;  8:  t = 32'h003FFFEA;
      9:  t = 32'h001FFFFD;  10: t = 32'h000FFFFF;  11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF;  13: t = 32'h0001FFFF;  14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF;  16: t = 32'h00003FFF;  17: t = 32'h00001FFF;
      18: t = 32'h00000FFF;  19: t = 32'h000007FF;  20: t = 32'h000003FF;
      21: t = 32'h000001FF;  22: t = 32'h000000FF;  23: t = 32'h0000007F;
      24: t = 32'h0000003F;  25: t = 32'h0000001F;  26: t = 32'h0000000F;
      27: t = 32'h00000007;  28: t = 32'h00000003;  29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return $signed({2'b00, t});
  endfunction

  // Round Q30 to Q12 with ties toward +infinity.
  function automatic logic signed [17:0] round_q12(input logic signed [35:0] v);
    logic signed [35:0] s;
    s = (v + 36'sd131072) >>> 18;
    return s[17:0];
  endfunction

  function automatic logic [15:0] sat_s16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'h7FFF;
    end else if (v < -18'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [13:0] sat_u14(input logic signed [17:0] v);
    if (v > 18'sd16383) begin
      return 14'h3FFF;
    end else if (v < 18'sd0) begin
      return 14'h0;
    end
    return v[13:0];
  endfunction

endpackage

@@ design/plik_cordic.sv @@
// ----------------------------------------------------------------------------
// plik_cordic: pipelined vectoring CORDIC computing atan2(v, u)
// Two normalization stages, then one register stage per iteration.
// ----------------------------------------------------------------------------
module plik_cordic #(
  parameter int TagW = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [31:0]                  u_i,
  input  logic signed [31:0]                  v_i,
  input  logic [TagW-1:0]                     tag_i,
  output logic                                valid_o,
  output logic signed [plik_pkg::CordicW-1:0] z_o,
  output logic [TagW-1:0]                     tag_o
);
  import plik_pkg::*;

  // Normalization stage: zero detect and left-shift count.
  logic               n0_valid_q;
  logic               n0_zero_q;
  logic [4:0]         n0_k_q;
  logic signed [31:0] n0_u_q, n0_v_q;
  logic [TagW-1:0]    n0_tag_q;

  logic [32:0] abs_u, abs_v, mag;
  logic [4:0]  k_d;

  always_comb begin
    abs_u = u_i[31] ? 33'(-{u_i[31], u_i}) : {1'b0, u_i};
    abs_v = v_i[31] ? 33'(-{v_i[31], v_i}) : {1'b0, v_i};
    mag   = (abs_u > abs_v) ? abs_u : abs_v;
    k_d   = '0;
    for (int j = 0; j < 29; j++) begin
      if (mag[j]) begin
        k_d = 5'(29 - j);
      end
    end
    if (|mag[32:29]) begin
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n0_valid_q <= 1'b0;
    end else begin
      n0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_zero_q <= (mag == '0);
    n0_k_q    <= k_d;
    n0_u_q    <= u_i;
    n0_v_q    <= v_i;
    n0_tag_q  <= tag_i;
  end

  // Rotation pipeline; index 0 holds the shifted, quadrant-corrected pair.
  logic                      valid_q [CordicIter+1];
  logic                      zero_q  [CordicIter+1];
  logic signed [CordicW-1:0] u_q     [CordicIter+1];
  logic signed [CordicW-1:0] v_q     [CordicIter+1];
  logic signed [CordicW-1:0] z_q     [CordicIter+1];
  logic [TagW-1:0]           tag_q   [CordicIter+1];

  logic signed [CordicW-1:0] su, sv, u0_d, v0_d, z0_d;

  always_comb begin
    su = $signed({{2{n0_u_q[31]}}, n0_u_q}) <<< n0_k_q;
    sv = $signed({{2{n0_v_q[31]}}, n0_v_q}) <<< n0_k_q;
    u0_d = su;
    v0_d = sv;
    z0_d = '0;
    if (su < 0) begin
      if (sv >= 0) begin
        u0_d = sv;
        v0_d = -su;
        z0_d = HalfPiQ30;
      end else begin
        u0_d = -sv;
        v0_d = su;
        z0_d = -HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= n0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= n0_zero_q;
    u_q[0]    <= u0_d;
    v_q[0]    <= v0_d;
    z_q[0]    <= z0_d;
    tag_q[0]  <= n0_tag_q;
  end

  for (genvar i = 0; i < CordicIter; i++) begin : g_iter
    localparam logic signed [CordicW-1:0] Ang = atan_lut(i);
    logic signed [CordicW-1:0] du, dv;
    assign du = v_q[i] >>> i;
    assign dv = u_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      tag_q[i+1]  <= tag_q[i];
      if (v_q[i] >= 0) begin
        u_q[i+1] <= u_q[i] + du;
        v_q[i+1] <= v_q[i] - dv;
        z_q[i+1] <= z_q[i] + Ang;
      end else begin
        u_q[i+1] <= u_q[i] - du;
        v_q[i+1] <= v_q[i] + dv;
        z_q[i+1] <= z_q[i] - Ang;
      end
    end
  end

  assign valid_o = valid_q[CordicIter];
  assign z_o     = zero_q[CordicIter] ? '0 : z_q[CordicIter];
  assign tag_o   = tag_q[CordicIter];

endmodule

@@ design/planar_two_link_ik_top.sv @@
// ----------------------------------------------------------------------------
// planar_two_link_ik_top: two-link planar inverse kinematics with wrist
// Target point in, joint angles out, Q3.12; the elbow angle is unsigned Q2.12.
// ----------------------------------------------------------------------------
// A point passes the input register, the first CORDIC, the multiply stages,
// the square-root stages, the second CORDIC and the output register.
// Throughput: one transaction per clock; busy is never raised.
// Reset clears only the valid bits; no result appears until one is started.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module planar_two_link_ik_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  plik_pkg::in_t    in_i,
  output logic             valid_o,
  output plik_pkg::out_t   out_o
);
  import plik_pkg::*;

  // The pipeline never stalls, so every start transaction is taken at once.
  assign busy = 1'b0;

  // Input register.
  logic s0_valid_q;
  in_t  s0_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_in_q <= in_i;
  end

  // First CORDIC gives theta = atan2(y, x); the raw point rides as the tag.
  logic                      c1_valid;
  logic signed [CordicW-1:0] c1_theta;
  in_t                       c1_pt;

  plik_cordic #(.TagW($bits(in_t))) u_cordic_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .u_i     (32'(s0_in_q.target_x)),
    .v_i     (32'(s0_in_q.target_y)),
    .tag_i   (s0_in_q),
    .valid_o (c1_valid),
    .z_o     (c1_theta),
    .tag_o   (c1_pt)
  );

  // Squares, then their sum r2 in Q8.24, then s^2 = r2 * (4 - r2).
  logic                      sq_valid_q, r2_valid_q, pr_valid_q;
  logic [31:0]               xx_q, yy_q, r2_q;
  logic signed [CordicW-1:0] sq_theta_q, r2_theta_q;
  logic signed [31:0]        xx_d, yy_d;
  logic [RootW-1:0]          diff;
  logic [RadW-1:0]           prod_d, prod_q;
  side_t                     pr_side_q;

  assign xx_d = c1_pt.target_x * c1_pt.target_x;
  assign yy_d = c1_pt.target_y * c1_pt.target_y;
  // Only meaningful within reach, where r2 fits in 27 bits.
  assign diff   = RootW'(ReachQ24) - r2_q[RootW-1:0];
  assign prod_d = RadW'(r2_q[RootW-1:0]) * RadW'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
      pr_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= c1_valid;
      r2_valid_q <= sq_valid_q;
      pr_valid_q <= r2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q       <= xx_d;
    yy_q       <= yy_d;
    sq_theta_q <= c1_theta;
    r2_q       <= xx_q + yy_q;
    r2_theta_q <= sq_theta_q;
    prod_q           <= prod_d;
    pr_side_q.theta  <= r2_theta_q;
    pr_side_q.far    <= (r2_q > ReachQ24);
    pr_side_q.origin <= (r2_q == '0);
    pr_side_q.r2     <= r2_q[RootW-1:0];
  end

  // Digit-by-digit square root, one root bit per stage, MSB first.
  // rem holds radicand minus root squared; root holds the bits found so far.
  logic             rt_valid_q [RootW+1];
  logic [RadW-1:0]  rem_q      [RootW+1];
  logic [RootW-1:0] root_q     [RootW+1];
  side_t            rt_side_q  [RootW+1];

  assign rt_valid_q[0] = pr_valid_q;
  assign rem_q[0]      = prod_q;
  assign root_q[0]     = '0;
  assign rt_side_q[0]  = pr_side_q;

  for (genvar j = 0; j < RootW; j++) begin : g_root
    localparam int B = RootW - 1 - j;
    logic [RadW-1:0] cand;
    assign cand = (RadW'(root_q[j]) << (B + 1)) + (RadW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_valid_q[j+1] <= 1'b0;
      end else begin
        rt_valid_q[j+1] <= rt_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_side_q[j+1] <= rt_side_q[j];
      if (rem_q[j] >= cand) begin
        rem_q[j+1]  <= rem_q[j] - cand;
        root_q[j+1] <= root_q[j] | (RootW'(1) << B);
      end else begin
        rem_q[j+1]  <= rem_q[j];
        root_q[j+1] <= root_q[j];
      end
    end
  end

  // Second CORDIC gives half the elbow angle as atan2(s, r2).
  localparam int Tag2W = CordicW + 3;

  logic                      c2_valid;
  logic signed [CordicW-1:0] c2_half;
  logic [Tag2W-1:0]          c2_tag;
  side_t                     sq_side;

  assign sq_side = rt_side_q[RootW];

  plik_cordic #(.TagW(Tag2W)) u_cordic_half (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid_q[RootW]),
    .u_i     (32'(sq_side.r2)),
    .v_i     (32'(root_q[RootW])),
    .tag_i   ({sq_side.theta, sq_side.far, sq_side.origin, (root_q[RootW] == '0)}),
    .valid_o (c2_valid),
    .z_o     (c2_half),
    .tag_o   (c2_tag)
  );

  // Pick the half angle for the special cases, then round and saturate.
  logic signed [CordicW-1:0] f_theta, f_half;
  logic                      f_far, f_origin, f_szero;
  logic signed [35:0]        sh_w, el_w, wr_w;
  out_t                      out_d;

  always_comb begin
    {f_theta, f_far, f_origin, f_szero} = c2_tag;
    if (f_far) begin
      f_half = '0;
    end else if (f_origin) begin
      f_half = HalfPiQ30;
    end else if (f_szero) begin
      f_half = '0;
    end else begin
      f_half = c2_half;
    end
    sh_w = 36'(f_theta) - 36'(f_half);
    el_w = 36'(f_half) <<< 1;
    wr_w = -36'(f_theta) - 36'(f_half);
    out_d.shoulder_angle = sat_s16(round_q12(sh_w));
    out_d.elbow_angle    = sat_u14(round_q12(el_w));
    out_d.wrist_angle    = sat_s16(round_q12(wr_w));
  end

  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= c2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_valid_q;
  assign out_o   = out_q;

endmodule

@@ tb/planar_two_link_ik_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_two_link_ik_checker: result predictor and scoreboard
// Watches accepted target points, predicts the three joint angles in fixed
// point and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module planar_two_link_ik_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  plik_pkg::in_t  in_i,
  input  logic           valid_i,
  input  plik_pkg::out_t out_i,
  output int             fail_count_o,
  output int             pending_o
);
  import plik_pkg::*;

  localparam longint HalfPi = 64'sd1686629713;
  localparam longint Reach  = 64'sd67108864;

  out_t angles_q[$];

  function automatic longint atan_step(input int i);
    longint t [30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001};
    return t[i];
  endfunction

  function automatic longint vec_angle(input longint v_in, input longint u_in);
    longint u, v, z, m, t, du, dv;
    u = u_in;
    v = v_in;
    z = 0;
    if (u == 0 && v == 0) return 0;
    m = (u < 0 ? -u : u) > (v < 0 ? -v : v) ? (u < 0 ? -u : u) : (v < 0 ? -v : v);
    while (m < (64'sd1 << 29)) begin
      u = u * 2;
      v = v * 2;
      m = m * 2;
    end
    if (u < 0) begin
      if (v >= 0) begin
        t = u; u = v; v = -t; z = HalfPi;
      end else begin
        t = u; u = -v; v = t; z = -HalfPi;
      end
    end
    for (int i = 0; i < 30; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u += du; v -= dv; z += atan_step(i);
      end else begin
        u -= du; v += dv; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint int_root(input longint unsigned n_in);
    longint unsigned n, res, b;
    n = n_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint to_q12(input longint v);
    return (v + (64'sd1 << 17)) >>> 18;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_t solve_joints(input in_t pt);
    longint x, y, r2, theta, half, s;
    out_t o;
    x = longint'(pt.target_x);
    y = longint'(pt.target_y);
    r2 = x * x + y * y;
    theta = vec_angle(y, x);
    if (r2 > Reach) begin
      half = 0;
    end else if (r2 == 0) begin
      half = HalfPi;
    end else begin
      s = int_root(longint'(r2 * (Reach - r2)));
      half = (s == 0) ? 0 : vec_angle(s, r2);
    end
    o.shoulder_angle = 16'(clamp(to_q12(theta - half), -32768, 32767));
    o.elbow_angle    = 14'(clamp(to_q12(2 * half), 0, 16383));
    o.wrist_angle    = 16'(clamp(to_q12(-theta - half), -32768, 32767));
    return o;
  endfunction

  assign pending_o = angles_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_o;
    int   errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (start_i && !busy_i) angles_q.insert(angles_q.size(), solve_joints(in_i));
      if (valid_i) begin
        if (angles_q.size() == 0) begin
          $error("unexpected result: shoulder %0d elbow %0d wrist %0d",
                 out_i.shoulder_angle, out_i.elbow_angle, out_i.wrist_angle);
          errs = errs + 1;
        end else begin
          exp_o = angles_q.pop_front();
          if (out_i.shoulder_angle !== exp_o.shoulder_angle) begin
            $error("shoulder_angle expected %0d actual %0d",
                   exp_o.shoulder_angle, out_i.shoulder_angle);
            errs = errs + 1;
          end
          if (out_i.elbow_angle !== exp_o.elbow_angle) begin
            $error("elbow_angle expected %0d actual %0d",
                   exp_o.elbow_angle, out_i.elbow_angle);
            errs = errs + 1;
          end
          if (out_i.wrist_angle !== exp_o.wrist_angle) begin
            $error("wrist_angle expected %0d actual %0d",
                   exp_o.wrist_angle, out_i.wrist_angle);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

@@ tb/planar_two_link_ik_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_two_link_ik_top_tb: regression for the two-link planar IK block
// Drives directed and random target points through several sender idling
// phases; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module planar_two_link_ik_top_tb;
  import plik_pkg::*;

  // Pipeline depth of the block, used to bound the drain waits.
  localparam int PipeDepth  = 96;
  localparam int StallLimit = 2000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  in_t    in_i = '0;
  logic   valid_o;
  out_t   out_o;
  int     fail_count;
  int     pending;
  int     idle_pct;
  int     quiet_cycles;
  logic   timed_out = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  planar_two_link_ik_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .out_o  (out_o)
  );

  planar_two_link_ik_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .in_i        (in_i),
    .valid_i     (valid_o),
    .out_i       (out_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Watchdog: the run is declared hung when no transaction is accepted and
  // no result strobes for a long stretch.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Sends one target point. The sender may idle first, depending on the
  // phase, and the point is held until the block takes it at a rising edge.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_i.target_x <= x;
    in_i.target_y <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly points in the square around the reachable disk, with a share
  // near the reach boundary region and some fully random points.
  task automatic send_random_point();
    int kind;
    int rad;
    logic signed [15:0] x;
    logic signed [15:0] y;
    kind = $urandom_range(9);
    if (kind < 6) begin
      x = 16'($signed($urandom_range(16383)) - 8192);
      y = 16'($signed($urandom_range(16383)) - 8192);
    end else if (kind < 8) begin
      // Near the reach circle of radius 2.0, i.e. 8192 in Q3.12.
      rad = $urandom_range(8200, 5700);
      x = 16'($signed($urandom_range(2 * rad)) - rad);
      y = ($urandom_range(1)) ? 16'(rad) : -16'(rad);
      if ($urandom_range(1)) begin
        {x, y} = {y, x};
      end
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    send_point(x, y);
  endtask

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed points: origin, exact reach on each axis, just beyond reach,
    // the field extremes, and each quadrant including the negative x axis.
    send_point(16'sd0, 16'sd0);
    send_point(16'sd8192, 16'sd0);
    send_point(16'sd0, 16'sd8192);
    send_point(-16'sd8192, 16'sd0);
    send_point(16'sd0, -16'sd8192);
    send_point(16'sd8193, 16'sd0);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(-16'sd32768, 16'sd0);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd1, 16'sd0);
    send_point(16'sd0, -16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd4096, 16'sd4096);
    send_point(-16'sd4096, 16'sd2048);
    send_point(-16'sd3000, -16'sd5000);
    send_point(16'sd2896, -16'sd2896);
    send_point(-16'sd4096, 16'sd0);
    send_point(16'sd5793, 16'sd5793);

    // Random phases: no idling, heavy idling, moderate idling, mixed.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 31;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 125; n++) begin
        if (phase == 3 && n % 25 == 0) idle_pct = (idle_pct == 0) ? 73 : 0;
        send_random_point();
      end
    end
    start <= 1'b0;

    // Drain: every prediction must be answered, then allow the pipeline
    // depth to pass so any stray result is caught.
    for (int w = 0; w < 4 * PipeDepth && pending != 0; w++) @(posedge clk_i);
    if (pending != 0) timed_out = 1'b1;
    repeat (PipeDepth + 4) @(posedge clk_i);

    if (fail_count == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/plik_pkg.sv
design/plik_cordic.sv
design/planar_two_link_ik_top.sv
tb/planar_two_link_ik_checker.sv
tb/planar_two_link_ik_top_tb.sv
